// ===== rtl/mccdmx_pkg.sv =====
// ----------------------------------------------------------------------------
// mccdmx_pkg: shared types and constants of the MIDI CC/NRPN to DMX mapper
// Register indexes, mode and command codes, field widths, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mccdmx_pkg;

  // Slot store geometry
  localparam int unsigned BANKS_DEF      = 32;
  localparam int unsigned SLOTS_PER_BANK = 512;
  localparam int unsigned BANK_W         = 5;
  localparam int unsigned SLOT_W         = 9;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DMX_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CC_ENABLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_ENABLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNIVERSE_BASE = 3'd4;

  // Register reset values
  localparam logic [1:0]  DMX_MODE_RST      = 2'd0;
  localparam logic        CC_ENABLE_RST     = 1'b1;
  localparam logic        NOTE_ENABLE_RST   = 1'b0;
  localparam logic [15:0] CHANNEL_MASK_RST  = 16'hFFFF;
  localparam logic [7:0]  UNIVERSE_BASE_RST = 8'd1;

  // Mapping modes
  localparam logic [1:0] MODE_CC7    = 2'd0;
  localparam logic [1:0] MODE_CC14   = 2'd1;
  localparam logic [1:0] MODE_NRPN7  = 2'd2;
  localparam logic [1:0] MODE_NRPN14 = 2'd3;

  // MIDI command nibbles
  localparam logic [3:0] CMD_NOTE_ON = 4'h9;
  localparam logic [3:0] CMD_CC      = 4'hB;

  // Controller numbers
  localparam logic [6:0] CC_DATA_MSB = 7'd6;
  localparam logic [6:0] CC_DATA_LSB = 7'd38;
  localparam logic [6:0] CC_DATA_INC = 7'd96;
  localparam logic [6:0] CC_DATA_DEC = 7'd97;
  localparam logic [6:0] CC_NRPN_LSB = 7'd98;
  localparam logic [6:0] CC_NRPN_MSB = 7'd99;
  localparam logic [6:0] CC14_LAST   = 7'd63;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_wr;  // write zero at the clear pointer and advance it
    logic accept;    // take the item on the input ports
    logic merge;     // finish the pending slot write and emit the result
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // clear pointer sits on the last store entry
  } dp_sts_t;

endpackage

// ===== rtl/mccdmx_ctrl.sv =====
// ----------------------------------------------------------------------------
// mccdmx_ctrl: sequencing controller
// Sweeps the slot store clear after reset, then takes one item at a time and
// follows each with a merge cycle.
// ----------------------------------------------------------------------------
module mccdmx_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  mccdmx_pkg::dp_sts_t   sts_i,
  output mccdmx_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MERGE
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (sts_i.clear_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_CLEAR;
        end
      endcase
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign cmd_o.clear_wr = (state_q == ST_CLEAR);
  assign cmd_o.accept   = (state_q == ST_IDLE) && start;
  assign cmd_o.merge    = (state_q == ST_MERGE);

endmodule

// ===== rtl/mccdmx_dp.sv =====
// ----------------------------------------------------------------------------
// mccdmx_dp: mapper datapath
// Configuration registers, NRPN and selection state, message decode, the
// slot store with its read-modify-write path, and the result registers.
// ----------------------------------------------------------------------------
module mccdmx_dp #(
  parameter int unsigned BANKS = mccdmx_pkg::BANKS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mccdmx_pkg::ctrl_cmd_t             cmd_i,
  output mccdmx_pkg::dp_sts_t               sts_o,
  input  logic                              cfg_we_i,
  input  logic [mccdmx_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mccdmx_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]                        status_byte_i,
  input  logic [6:0]                        first_data_i,
  input  logic [6:0]                        second_data_i,
  output logic                              result_valid_o,
  output logic [7:0]                        universe_number_o,
  output logic [mccdmx_pkg::BANK_W-1:0]     buffer_index_o,
  output logic [mccdmx_pkg::SLOT_W-1:0]     slot_index_o,
  output logic [7:0]                        slot_value_o,
  output logic                              send_universe_o
);

  localparam int unsigned BW     = $clog2(BANKS);
  localparam int unsigned ADDR_W = BW + mccdmx_pkg::SLOT_W;
  localparam int unsigned DEPTH  = BANKS * mccdmx_pkg::SLOTS_PER_BANK;

  // How the pending slot value is formed in the merge cycle
  typedef enum logic [1:0] {
    MK_DIRECT,  // value is complete
    MK_HIGH,    // replace bits 7..1, keep stored bit 0
    MK_LOW      // replace bit 0, keep stored bits 7..1
  } merge_e;

  // Configuration registers
  logic [1:0]  mode_q;
  logic        cc_en_q;
  logic        note_en_q;
  logic [15:0] chan_mask_q;
  logic [7:0]  univ_base_q;

  // Selection and data entry state
  logic [13:0]                   param_q, param_d;
  logic [7:0]                    entry_q, entry_d;
  logic [mccdmx_pkg::SLOT_W-1:0] cur_slot_q, cur_slot_d;
  logic [mccdmx_pkg::BANK_W-1:0] cur_bank_q, cur_bank_d;
  logic [7:0]                    cur_univ_q, cur_univ_d;

  // Pending write between accept and merge
  logic                          pend_hit_q, hit_d;
  merge_e                        pend_kind_q, kind_d;
  logic                          pend_bank_ok_q, bank_ok_d;
  logic [mccdmx_pkg::BANK_W-1:0] pend_bank_q, p_bank_d;
  logic [mccdmx_pkg::SLOT_W-1:0] pend_slot_q, p_slot_d;
  logic [7:0]                    pend_val_q, p_val_d;
  logic                          pend_send_q, p_send_d;
  logic [7:0]                    pend_univ_q, p_univ_d;

  // Slot store
  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_data_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;
  logic [7:0]        wr_data;
  logic [7:0]        base_val;
  logic [7:0]        merged_val;

  // Result registers
  logic                          res_valid_q;
  logic [7:0]                    res_univ_q;
  logic [mccdmx_pkg::BANK_W-1:0] res_bank_q;
  logic [mccdmx_pkg::SLOT_W-1:0] res_slot_q;
  logic [7:0]                    res_val_q;
  logic                          res_send_q;

  // Decode
  logic [3:0] cmd_nib;
  logic [3:0] chan;
  logic       chan_ok;
  logic       cc_hit;
  logic       note_hit;
  logic       fine;

  assign cmd_nib  = status_byte_i[7:4];
  assign chan     = status_byte_i[3:0];
  assign chan_ok  = chan_mask_q[chan];
  assign cc_hit   = cc_en_q && (cmd_nib == mccdmx_pkg::CMD_CC) && chan_ok;
  assign note_hit = note_en_q && (cmd_nib == mccdmx_pkg::CMD_NOTE_ON) && chan_ok;
  assign fine     = (mode_q == mccdmx_pkg::MODE_NRPN14);

  always_comb begin
    param_d    = param_q;
    entry_d    = entry_q;
    cur_slot_d = cur_slot_q;
    cur_bank_d = cur_bank_q;
    cur_univ_d = cur_univ_q;
    hit_d      = 1'b0;
    kind_d     = MK_DIRECT;
    p_bank_d   = cur_bank_q;
    p_slot_d   = cur_slot_q;
    p_val_d    = entry_q;
    p_send_d   = 1'b1;
    p_univ_d   = cur_univ_q;

    if (cmd_i.accept) begin
      if (note_hit || (cc_hit && (mode_q == mccdmx_pkg::MODE_CC7))) begin
        cur_univ_d = {4'd0, chan} + univ_base_q;
        cur_bank_d = {1'b0, chan};
        hit_d      = 1'b1;
        p_bank_d   = {1'b0, chan};
        p_slot_d   = {2'd0, first_data_i};
        p_val_d    = {second_data_i, 1'b0};
        p_univ_d   = cur_univ_d;
      end else if (cc_hit && (mode_q == mccdmx_pkg::MODE_CC14)) begin
        if (first_data_i <= mccdmx_pkg::CC14_LAST) begin
          cur_slot_d = {chan, first_data_i[4:0]};
          hit_d      = 1'b1;
          p_slot_d   = cur_slot_d;
          if (first_data_i[5]) begin
            kind_d   = MK_LOW;
            p_val_d  = {7'd0, second_data_i[6]};
          end else begin
            kind_d   = MK_HIGH;
            p_val_d  = {second_data_i, 1'b0};
            p_send_d = 1'b0;
          end
        end
      end else if (cc_hit) begin
        case (first_data_i)
          mccdmx_pkg::CC_NRPN_LSB, mccdmx_pkg::CC_NRPN_MSB: begin
            if (first_data_i == mccdmx_pkg::CC_NRPN_LSB) begin
              param_d = {param_q[13:7], second_data_i};
            end else begin
              param_d = {second_data_i, param_q[6:0]};
            end
            cur_slot_d = param_d[8:0];
            cur_bank_d = param_d[13:9];
            cur_univ_d = {3'd0, param_d[13:9]} + univ_base_q;
          end
          mccdmx_pkg::CC_DATA_MSB: begin
            if (fine) begin
              entry_d = {second_data_i, entry_q[0]};
            end else begin
              entry_d = {second_data_i, 1'b0};
              hit_d   = 1'b1;
            end
          end
          mccdmx_pkg::CC_DATA_LSB: begin
            if (fine) begin
              entry_d = {entry_q[7:1], second_data_i[6]};
              hit_d   = 1'b1;
            end
          end
          mccdmx_pkg::CC_DATA_INC: begin
            if (entry_q != 8'hFF) begin
              entry_d = entry_q + 8'd1;
              hit_d   = 1'b1;
            end
          end
          mccdmx_pkg::CC_DATA_DEC: begin
            if (!fine) begin
              cur_slot_d = param_q[8:0];
            end
            if (entry_q != 8'd0) begin
              entry_d = entry_q - 8'd1;
              hit_d   = 1'b1;
            end
          end
          default: begin
          end
        endcase
        p_slot_d = cur_slot_d;
        p_val_d  = entry_d;
      end
    end

    // A new universe base also reselects the current universe
    if (cfg_we_i && (cfg_index_i == mccdmx_pkg::REG_UNIVERSE_BASE)) begin
      cur_univ_d = cfg_data_i[7:0];
    end
  end

  assign bank_ok_d = ({1'b0, p_bank_d} < (mccdmx_pkg::BANK_W + 1)'(BANKS));
  assign rd_addr   = {p_bank_d[BW-1:0], p_slot_d};

  // Configuration and selection state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= mccdmx_pkg::DMX_MODE_RST;
      cc_en_q     <= mccdmx_pkg::CC_ENABLE_RST;
      note_en_q   <= mccdmx_pkg::NOTE_ENABLE_RST;
      chan_mask_q <= mccdmx_pkg::CHANNEL_MASK_RST;
      univ_base_q <= mccdmx_pkg::UNIVERSE_BASE_RST;
      param_q     <= '0;
      entry_q     <= '0;
      cur_slot_q  <= '0;
      cur_bank_q  <= '0;
      cur_univ_q  <= mccdmx_pkg::UNIVERSE_BASE_RST;
      pend_hit_q  <= 1'b0;
      res_valid_q <= 1'b0;
      clr_addr_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          mccdmx_pkg::REG_DMX_MODE:      mode_q      <= cfg_data_i[1:0];
          mccdmx_pkg::REG_CC_ENABLE:     cc_en_q     <= cfg_data_i[0];
          mccdmx_pkg::REG_NOTE_ENABLE:   note_en_q   <= cfg_data_i[0];
          mccdmx_pkg::REG_CHANNEL_MASK:  chan_mask_q <= cfg_data_i[15:0];
          mccdmx_pkg::REG_UNIVERSE_BASE: univ_base_q <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
      param_q    <= param_d;
      entry_q    <= entry_d;
      cur_slot_q <= cur_slot_d;
      cur_bank_q <= cur_bank_d;
      cur_univ_q <= cur_univ_d;
      if (cmd_i.accept) begin
        pend_hit_q <= hit_d;
      end else if (cmd_i.merge) begin
        pend_hit_q <= 1'b0;
      end
      res_valid_q <= cmd_i.merge && pend_hit_q;
      if (cmd_i.clear_wr) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
    end
  end

  // Pending write payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pend_kind_q    <= kind_d;
      pend_bank_ok_q <= bank_ok_d;
      pend_bank_q    <= p_bank_d;
      pend_slot_q    <= p_slot_d;
      pend_val_q     <= p_val_d;
      pend_send_q    <= p_send_d;
      pend_univ_q    <= p_univ_d;
    end
  end

  // Merge: a bank past the store reads as zero and drops its write
  assign base_val = pend_bank_ok_q ? rd_data_q : 8'd0;

  always_comb begin
    case (pend_kind_q)
      MK_HIGH: merged_val = {pend_val_q[7:1], base_val[0]};
      MK_LOW:  merged_val = {base_val[7:1], pend_val_q[0]};
      default: merged_val = pend_val_q;
    endcase
  end

  assign wr_en   = cmd_i.clear_wr || (cmd_i.merge && pend_hit_q && pend_bank_ok_q);
  assign wr_addr = cmd_i.clear_wr ? clr_addr_q : {pend_bank_q[BW-1:0], pend_slot_q};
  assign wr_data = cmd_i.clear_wr ? 8'd0 : merged_val;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.accept) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.merge) begin
      res_univ_q <= pend_univ_q;
      res_bank_q <= pend_bank_q;
      res_slot_q <= pend_slot_q;
      res_val_q  <= merged_val;
      res_send_q <= pend_send_q;
    end
  end

  assign sts_o.clear_last = (clr_addr_q == ADDR_W'(DEPTH - 1));

  assign result_valid_o    = res_valid_q;
  assign universe_number_o = res_univ_q;
  assign buffer_index_o    = res_bank_q;
  assign slot_index_o      = res_slot_q;
  assign slot_value_o      = res_val_q;
  assign send_universe_o   = res_send_q;

endmodule

// ===== rtl/midi_cc_nrpn_to_dmx_mapper.sv =====
// ----------------------------------------------------------------------------
// midi_cc_nrpn_to_dmx_mapper: MIDI control change / NRPN to DMX slot mapper
// Maps three-byte MIDI messages onto a banked DMX slot store and reports
// every slot write.
// ----------------------------------------------------------------------------
// Usage:
//   Present a MIDI message on status_byte_i, first_data_i and second_data_i
//   and raise start; the item is taken at a rising edge where start is high
//   and busy is low.
//   Configuration registers are written through cfg_we_i, cfg_index_i and
//   cfg_data_i at any edge with cfg_we_i high; indexes past the last register
//   are ignored. Write them only while no item is in flight.
//   For each item the accept edge decodes it, updates the NRPN and selection
//   state and reads the slot store; the following merge cycle completes the
//   read-modify-write of the slot. busy is high in the merge cycle, so a new
//   item is taken only once the merge of the last one is done, set by the
//   single store port pair and its registered read.
//   A slot write shows on the result ports with result_valid_o high for one
//   cycle, the cycle right after the merge cycle. Messages that select no
//   slot give no strobe; a bank past the store still gives one, though its
//   write is dropped. The receiver cannot stall; results are not held.
//   After reset the block sweeps the slot store clear, one entry per cycle,
//   through all BANKS*512 entries, holding busy high throughout.
// ----------------------------------------------------------------------------
module midi_cc_nrpn_to_dmx_mapper #(
  parameter int unsigned BANKS = mccdmx_pkg::BANKS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Item channel
  input  logic                              start,
  output logic                              busy,
  input  logic [7:0]                        status_byte_i,
  input  logic [6:0]                        first_data_i,
  input  logic [6:0]                        second_data_i,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [mccdmx_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mccdmx_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Result channel
  output logic                              result_valid_o,
  output logic [7:0]                        universe_number_o,
  output logic [mccdmx_pkg::BANK_W-1:0]     buffer_index_o,
  output logic [mccdmx_pkg::SLOT_W-1:0]     slot_index_o,
  output logic [7:0]                        slot_value_o,
  output logic                              send_universe_o
);

  mccdmx_pkg::ctrl_cmd_t cmd;
  mccdmx_pkg::dp_sts_t   sts;

  // Sequence clear sweep, accept and merge
  mccdmx_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Decode, hold state, and run the slot store
  mccdmx_dp #(
    .BANKS (BANKS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .status_byte_i     (status_byte_i),
    .first_data_i      (first_data_i),
    .second_data_i     (second_data_i),
    .result_valid_o    (result_valid_o),
    .universe_number_o (universe_number_o),
    .buffer_index_o    (buffer_index_o),
    .slot_index_o      (slot_index_o),
    .slot_value_o      (slot_value_o),
    .send_universe_o   (send_universe_o)
  );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the MIDI CC/NRPN to DMX slot mapper
// Drives MIDI messages through the start/busy handshake, predicts every slot
// write with a mirror of the slot store, the NRPN selection and the
// configuration, and checks each result strobe against that prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import mccdmx_pkg::*;

  // Command nibbles used only as noise
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_SYSTEM   = 4'hF;
  // Register index past the last register, ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] ctrl;
    logic [6:0] value;
  } midi_msg_t;

  typedef struct packed {
    logic [7:0]        universe;
    logic [BANK_W-1:0] bank;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        value;
    logic              send;
  } dmx_write_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  start          = 1'b0;
  logic                  busy;
  logic [7:0]            status_byte_i  = '0;
  logic [6:0]            first_data_i   = '0;
  logic [6:0]            second_data_i  = '0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  result_valid_o;
  logic [7:0]            universe_number_o;
  logic [BANK_W-1:0]     buffer_index_o;
  logic [SLOT_W-1:0]     slot_index_o;
  logic [7:0]            slot_value_o;
  logic                  send_universe_o;

  midi_cc_nrpn_to_dmx_mapper u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .status_byte_i     (status_byte_i),
    .first_data_i      (first_data_i),
    .second_data_i     (second_data_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .result_valid_o    (result_valid_o),
    .universe_number_o (universe_number_o),
    .buffer_index_o    (buffer_index_o),
    .slot_index_o      (slot_index_o),
    .slot_value_o      (slot_value_o),
    .send_universe_o   (send_universe_o)
  );

  // --------------------------------------------------------------------------
  // Mirror of the block: configuration, NRPN selection and the slot store
  // --------------------------------------------------------------------------
  logic [1:0]          cfg_mode      = DMX_MODE_RST;
  logic                cfg_cc_en     = CC_ENABLE_RST;
  logic                cfg_note_en   = NOTE_ENABLE_RST;
  logic [15:0]         cfg_chan_mask = CHANNEL_MASK_RST;
  logic [7:0]          cfg_univ_base = UNIVERSE_BASE_RST;

  logic [13:0]         nrpn_param    = '0;
  logic [7:0]          entry_val     = '0;
  logic [SLOT_W-1:0]   sel_slot      = '0;
  logic [BANK_W-1:0]   sel_bank      = '0;
  logic [7:0]          sel_universe  = UNIVERSE_BASE_RST;
  logic [7:0]          slot_mem [0:BANKS_DEF*SLOTS_PER_BANK-1];

  midi_msg_t  pending_msgs[$];    // items waiting for the driver
  dmx_write_t dmx_writes_due[$];  // slot writes predicted, not yet seen

  int n_fail   = 0;
  int gap_left = 0;
  bit idle_on  = 1'b1;

  // Record one slot write: update the mirror store and queue the result.
  // All 32 banks exist at the default size, so every write lands.
  task automatic post_slot(input logic [BANK_W-1:0] bank, input logic [SLOT_W-1:0] slot,
                           input logic [7:0] value, input logic send);
    slot_mem[{bank, slot}] = value;
    dmx_writes_due.push_back({sel_universe, bank, slot, value, send});
  endtask

  task automatic cc7_write(input logic [3:0] chan, input logic [6:0] ctrl,
                           input logic [6:0] value);
    sel_bank     = {1'b0, chan};
    sel_universe = cfg_univ_base + {4'd0, chan};
    post_slot(sel_bank, {2'b00, ctrl}, {value, 1'b0}, 1'b1);
  endtask

  // Coarse controllers 0..31 set bits 7..1 and hold off sending; fine
  // controllers 32..63 set bit 0 from the value's top bit and send.
  task automatic cc14_write(input logic [3:0] chan, input logic [6:0] ctrl,
                            input logic [6:0] value);
    logic [7:0] cur;
    if (ctrl <= CC14_LAST) begin
      sel_slot = {chan, ctrl[4:0]};
      cur      = slot_mem[{sel_bank, sel_slot}];
      if (ctrl[5]) begin
        cur[0] = value[6];
        post_slot(sel_bank, sel_slot, cur, 1'b1);
      end else begin
        post_slot(sel_bank, sel_slot, {value, cur[0]}, 1'b0);
      end
    end
  endtask

  task automatic select_param();
    sel_slot     = nrpn_param[8:0];
    sel_bank     = nrpn_param[13:9];
    sel_universe = cfg_univ_base + {3'd0, sel_bank};
  endtask

  task automatic nrpn_step(input logic fine, input logic [6:0] ctrl, input logic [6:0] value);
    case (ctrl)
      CC_NRPN_LSB: begin
        nrpn_param[6:0] = value;
        select_param();
      end
      CC_NRPN_MSB: begin
        nrpn_param[13:7] = value;
        select_param();
      end
      CC_DATA_MSB: begin
        if (fine) begin
          entry_val[7:1] = value;
        end else begin
          entry_val = {value, 1'b0};
          post_slot(sel_bank, sel_slot, entry_val, 1'b1);
        end
      end
      CC_DATA_LSB: begin
        if (fine) begin
          entry_val[0] = value[6];
          post_slot(sel_bank, sel_slot, entry_val, 1'b1);
        end
      end
      CC_DATA_INC: begin
        // saturate at full scale: no write
        if (entry_val != 8'hFF) begin
          entry_val = entry_val + 8'd1;
          post_slot(sel_bank, sel_slot, entry_val, 1'b1);
        end
      end
      CC_DATA_DEC: begin
        // the 7-bit flavor re-points the slot before the zero check
        if (!fine) sel_slot = nrpn_param[8:0];
        if (entry_val != 8'h00) begin
          entry_val = entry_val - 8'd1;
          post_slot(sel_bank, sel_slot, entry_val, 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  // Predict the slot writes caused by one accepted item
  task automatic map_midi_msg(input midi_msg_t msg);
    logic [3:0] cmd;
    logic [3:0] chan;
    cmd  = msg.status[7:4];
    chan = msg.status[3:0];
    if (cfg_cc_en && cmd == CMD_CC) begin
      if (cfg_chan_mask[chan]) begin
        case (cfg_mode)
          MODE_CC7:  cc7_write(chan, msg.ctrl, msg.value);
          MODE_CC14: cc14_write(chan, msg.ctrl, msg.value);
          default:   nrpn_step(cfg_mode == MODE_NRPN14, msg.ctrl, msg.value);
        endcase
      end
    end else if (cfg_note_en && cmd == CMD_NOTE_ON && cfg_chan_mask[chan]) begin
      cc7_write(chan, msg.ctrl, msg.value);
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset release and watchdog
  // --------------------------------------------------------------------------
  initial begin : gen_clock
    forever #5 clk_i = ~clk_i;
  end

  // The watchdog bounds the whole run, the post-reset clear sweep included,
  // even with every idle burst at its longest.
  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: present the oldest pending item, hold it while busy, predict it
  // on the accepting edge, then insert a random idle burst now and then.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_items
    midi_msg_t next_msg;
    if (rst_ni) begin
      if (start && !busy) begin
        map_midi_msg({status_byte_i, first_data_i, second_data_i});
      end
      if (!start || !busy) begin
        if (gap_left > 0 || pending_msgs.size() == 0) begin
          start <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          next_msg      = pending_msgs.pop_front();
          start         <= 1'b1;
          status_byte_i <= next_msg.status;
          first_data_i  <= next_msg.ctrl;
          second_data_i <= next_msg.value;
          if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 4);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every strobe must match the oldest predicted slot write
  // --------------------------------------------------------------------------
  function automatic string fmt_write(input dmx_write_t w);
    return $sformatf("universe %0d bank %0d slot %0d value 0x%02h send %0b",
                     w.universe, w.bank, w.slot, w.value, w.send);
  endfunction

  task automatic report_mismatch(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("MISMATCH: %s", msg);
  endtask

  always @(posedge clk_i) begin : check_results
    dmx_write_t seen;
    dmx_write_t want;
    if (rst_ni && result_valid_o) begin
      seen = {universe_number_o, buffer_index_o, slot_index_o, slot_value_o, send_universe_o};
      if (dmx_writes_due.size() == 0) begin
        report_mismatch({"unexpected slot write: ", fmt_write(seen)});
      end else begin
        want = dmx_writes_due.pop_front();
        if (seen.universe !== want.universe || seen.bank !== want.bank ||
            seen.slot !== want.slot || seen.value !== want.value ||
            seen.send !== want.send) begin
          report_mismatch({"expected ", fmt_write(want), ", got ", fmt_write(seen)});
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_msg(input logic [7:0] status, input logic [6:0] ctrl,
                           input logic [6:0] value);
    pending_msgs.push_back({status, ctrl, value});
  endtask

  // Write one register while idle and mirror it when the write is driven
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      REG_DMX_MODE:      cfg_mode      = data[1:0];
      REG_CC_ENABLE:     cfg_cc_en     = data[0];
      REG_NOTE_ENABLE:   cfg_note_en   = data[0];
      REG_CHANNEL_MASK:  cfg_chan_mask = data;
      REG_UNIVERSE_BASE: begin
        cfg_univ_base = data[7:0];
        sel_universe  = data[7:0];
      end
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait for every queued item to be taken and every predicted write to show,
  // then let the last no-result item finish its merge cycle.
  task automatic settle();
    int waited;
    waited = 0;
    while (pending_msgs.size() != 0 || start) @(posedge clk_i);
    while (dmx_writes_due.size() != 0 && waited < 64) begin
      @(posedge clk_i);
      waited++;
    end
    if (dmx_writes_due.size() != 0) begin
      report_mismatch($sformatf("%0d predicted slot writes never reported",
                                dmx_writes_due.size()));
      dmx_writes_due.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Data byte biased to the ends and to the 63/64 threshold of the fine bit
  function automatic logic [6:0] rand_data();
    case ($urandom_range(0, 9))
      0, 1:    return 7'd0;
      2, 3:    return 7'd127;
      4:       return 7'd63;
      5:       return 7'd64;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [6:0] pick_entry_cc();
    case ($urandom_range(0, 3))
      0:       return CC_DATA_MSB;
      1:       return CC_DATA_LSB;
      2:       return CC_DATA_INC;
      default: return CC_DATA_DEC;
    endcase
  endfunction

  function automatic logic [6:0] rand_ctrl();
    if (cfg_mode == MODE_CC14 && $urandom_range(0, 4) != 0) return 7'($urandom_range(0, 63));
    if (cfg_mode[1] && $urandom_range(0, 9) < 5) return pick_entry_cc();
    if (cfg_mode[1] && $urandom_range(0, 4) == 0) begin
      return ($urandom_range(0, 1) == 0) ? CC_NRPN_LSB : CC_NRPN_MSB;
    end
    return 7'($urandom_range(0, 127));
  endfunction

  // Mostly well-formed traffic for the current mode: in the NRPN modes,
  // select a parameter and follow it with a run of data-entry controllers.
  task automatic queue_random_phase(input int n_msgs);
    int         left;
    int         burst;
    logic [3:0] chan;
    left = n_msgs;
    while (left > 0) begin
      chan = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) begin
        queue_msg(8'($urandom), 7'($urandom), 7'($urandom));
        left--;
      end else if (cfg_mode[1] && $urandom_range(0, 3) != 0) begin
        queue_msg({CMD_CC, chan}, CC_NRPN_MSB, 7'($urandom_range(0, 127)));
        queue_msg({CMD_CC, chan}, CC_NRPN_LSB, 7'($urandom_range(0, 127)));
        burst = $urandom_range(1, 6);
        repeat (burst) queue_msg({CMD_CC, chan}, pick_entry_cc(), rand_data());
        left -= burst + 2;
      end else begin
        queue_msg({($urandom_range(0, 3) == 0) ? CMD_NOTE_ON : CMD_CC, chan},
                  rand_ctrl(), rand_data());
        left--;
      end
    end
  endtask

  // Rewrite all registers, with junk in the unused upper data bits
  task automatic set_random_config(input int phase);
    logic [15:0] data;
    data      = 16'($urandom);
    data[1:0] = (phase < 8) ? 2'(phase % 4) : 2'($urandom_range(0, 3));
    write_reg(REG_DMX_MODE, data);
    data    = 16'($urandom);
    data[0] = ($urandom_range(0, 7) != 0);
    write_reg(REG_CC_ENABLE, data);
    write_reg(REG_NOTE_ENABLE, 16'($urandom));
    case ($urandom_range(0, 9))
      0:             data = 16'h0000;
      1, 2, 3, 4, 5: data = 16'hFFFF;
      default:       data = 16'($urandom);
    endcase
    write_reg(REG_CHANNEL_MASK, data);
    data = 16'($urandom);
    case ($urandom_range(0, 5))
      0:       data[7:0] = 8'h00;
      1:       data[7:0] = 8'hFF;
      default: ;
    endcase
    write_reg(REG_UNIVERSE_BASE, data);
    if ($urandom_range(0, 3) == 0) write_reg(3'($urandom_range(5, 7)), 16'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run_stimulus
    int phase;
    foreach (slot_mem[i]) slot_mem[i] = 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings (cc7): field extremes, note-on while disabled, noise.
    // The driver holds the first item until the clear sweep drops busy.
    queue_msg({CMD_CC, 4'd0}, 7'd0, 7'd0);
    queue_msg({CMD_CC, 4'd15}, 7'd127, 7'd127);
    queue_msg({CMD_CC, 4'd6}, 7'd42, 7'd85);
    queue_msg({CMD_NOTE_ON, 4'd15}, 7'd127, 7'd127);
    queue_msg({CMD_SYSTEM, 4'd15}, 7'd127, 7'd127);
    settle();

    // Note-on enabled, masked channels, universe number wrapping past 255
    write_reg(REG_NOTE_ENABLE, 16'h0001);
    write_reg(REG_CHANNEL_MASK, 16'h7FFE);
    write_reg(REG_UNIVERSE_BASE, 16'h00FF);
    queue_msg({CMD_NOTE_ON, 4'd0}, 7'd1, 7'd127);
    queue_msg({CMD_NOTE_ON, 4'd1}, 7'd127, 7'd1);
    queue_msg({CMD_CC, 4'd15}, 7'd5, 7'd5);
    settle();

    // cc14: coarse, fine set and clear, first ignored and last valid controller
    write_reg(REG_DMX_MODE, {14'd0, MODE_CC14});
    write_reg(REG_CHANNEL_MASK, 16'hFFFF);
    write_reg(REG_UNIVERSE_BASE, 16'h0000);
    queue_msg({CMD_CC, 4'd3}, 7'd5, 7'd127);
    queue_msg({CMD_CC, 4'd3}, 7'd37, 7'd64);
    queue_msg({CMD_CC, 4'd3}, 7'd37, 7'd63);
    queue_msg({CMD_CC, 4'd3}, 7'd64, 7'd127);
    queue_msg({CMD_CC, 4'd3}, CC14_LAST, 7'd64);
    settle();

    // nrpn7: top parameter, entry, increment to and past full scale,
    // decrement with slot reload, decrement saturated at zero
    write_reg(REG_DMX_MODE, {14'd0, MODE_NRPN7});
    queue_msg({CMD_CC, 4'd0}, CC_NRPN_MSB, 7'd127);
    queue_msg({CMD_CC, 4'd0}, CC_NRPN_LSB, 7'd127);
    queue_msg({CMD_CC, 4'd0}, CC_DATA_MSB, 7'd127);
    queue_msg({CMD_CC, 4'd0}, CC_DATA_INC, 7'd0);
    queue_msg({CMD_CC, 4'd0}, CC_DATA_INC, 7'd0);
    queue_msg({CMD_CC, 4'd0}, CC_DATA_DEC, 7'd0);
    queue_msg({CMD_CC, 4'd0}, CC_DATA_MSB, 7'd0);
    queue_msg({CMD_CC, 4'd0}, CC_DATA_DEC, 7'd0);
    settle();

    // Control changes disabled: only note-ons get through
    write_reg(REG_DMX_MODE, {14'd0, MODE_NRPN14});
    write_reg(REG_CC_ENABLE, 16'h0000);
    queue_msg({CMD_CC, 4'd0}, CC_DATA_MSB, 7'd127);
    queue_msg({CMD_NOTE_ON, 4'd2}, 7'd3, 7'd4);
    settle();

    // nrpn14: coarse entry holds, fine entry writes, decrement keeps slot
    write_reg(REG_CC_ENABLE, 16'h0001);
    write_reg(REG_UNUSED, 16'hFFFF);
    queue_msg({CMD_CC, 4'd0}, CC_DATA_MSB, 7'd127);
    queue_msg({CMD_CC, 4'd0}, CC_DATA_LSB, 7'd64);
    queue_msg({CMD_CC, 4'd0}, CC_DATA_LSB, 7'd63);
    queue_msg({CMD_CC, 4'd0}, CC_DATA_DEC, 7'd0);
    settle();

    // Random phases; drop idle bursts in the last two
    for (phase = 0; phase < 14; phase++) begin
      set_random_config(phase);
      if (phase >= 12) idle_on = 1'b0;
      queue_random_phase(45);
      settle();
    end

    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
